@@ src/tcb_pkg.sv @@
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared widths, register indexes and limits of the coincidence event builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

  localparam int STAMP_W     = 48;
  localparam int EVENT_W     = 32;
  localparam int WIN_W       = 32;
  localparam int HIST_W      = 40;
  localparam int FRAC_W      = 8;
  localparam int MAX_STREAMS = 4;
  localparam int MAX_SW      = 2;
  localparam int MAX_RESULTS = 16;

  localparam int IN_EV_BASE  = MAX_STREAMS * STAMP_W;
  localparam int OUT_ST_BASE = MAX_STREAMS * EVENT_W;
  localparam int TDATA_W     = MAX_STREAMS * (STAMP_W + EVENT_W);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW_1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW_3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH_3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK      = 3'd6;

  localparam logic signed [WIN_W-1:0] WIN_LOW_RST  = -32'sd1000;
  localparam logic signed [WIN_W-1:0] WIN_HIGH_RST = 32'sd1000;

  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ src/tcb_div.sv @@
// ----------------------------------------------------------------------------
// tcb_div
// Bit-serial signed by unsigned divider, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_div #(
  parameter int DVD_W = 45,
  parameter int DVS_W = 5,
  parameter int Q_W   = 40
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire  signed [DVD_W-1:0] dividend_i,
  input  wire         [DVS_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [Q_W-1:0]   quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] mag_q, mag_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [Q_W-1:0]   qmag;

  always_comb begin
    rem_sh = {rem_q, mag_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[DVD_W-1];
      mag_d  = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    end else if (busy_q) begin
      mag_d = {mag_q[DVD_W-2:0], ge};
      rem_d = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign qmag       = mag_q[Q_W-1:0];
  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(-qmag) : $signed(qmag);

endmodule

`default_nettype wire

@@ src/timestamp_coincidence_event_builder_top.sv @@
// ----------------------------------------------------------------------------
// timestamp_coincidence_event_builder_top
// Per-stream timestamp FIFOs matched against stream 0 within offset windows.
// ----------------------------------------------------------------------------
// Input beat on s_axis carries one timestamp and event number per stream;
// each is appended to that stream's FIFO (oldest entry dropped when full).
// Matching then walks the FIFO heads under one sequencer: each compare of a
// head against the reference runs subtract, add averaged offset and window
// compare, after a read and a write step per head first fetched from the
// FIFO RAM. With offset tracking on, a match runs the tracking steps for
// each stream from 1 up, a read, subtract and add per history push and a
// closing step; each stream whose history changed re-averages in the serial
// divider, and a last step ends the re-averaging. An input beat is accepted,
// pushed into each stream's FIFO in turn, matched in passes that each open
// with a start step, and closed; up to 16 matches leave per beat on m_axis,
// tlast on the last. s_axis_tready_o is high only while the sequencer is idle.
// One result is held back so tlast can be set; a stalled m_axis holds the
// sequencer only when both the output register and that holding stage are
// full. Reset empties FIFOs and histories and loads default windows; the
// config channel is always ready and should be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_coincidence_event_builder_top #(
  parameter int NUM_STREAMS   = 4,
  parameter int FIFO_DEPTH    = 16,
  parameter int HISTORY_DEPTH = 11
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // stamp_a, stamp_b, stamp_c, stamp_d, event_a, event_b, event_c, event_d
  input  wire  [tcb_pkg::TDATA_W-1:0]      s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // match_event_a..d, match_stamp_a..d
  output logic [tcb_pkg::TDATA_W-1:0]      m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [tcb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [tcb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int SW      = $clog2(NUM_STREAMS);
  localparam int SCNT_W  = $clog2(NUM_STREAMS + 1);
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FCNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int HP_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = tcb_pkg::HIST_W + HCNT_W;
  localparam int ENT_W   = tcb_pkg::STAMP_W + tcb_pkg::EVENT_W;
  localparam int DIFF_W  = tcb_pkg::STAMP_W + 1;
  localparam int REL_W   = DIFF_W + tcb_pkg::FRAC_W;
  localparam int D_W     = REL_W + 1;
  localparam int MEAN_W  = tcb_pkg::WIN_W + tcb_pkg::FRAC_W;
  localparam int DEV1_W  = REL_W + 1;
  localparam int DEV_W   = DEV1_W + 1;
  localparam int N_W     = $clog2(tcb_pkg::MAX_RESULTS + 1);
  localparam int TD_W    = tcb_pkg::TDATA_W;
  localparam int WI_W    = tcb_pkg::MAX_SW;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PUSH  = 5'd1;
  localparam logic [4:0] ST_START = 5'd2;
  localparam logic [4:0] ST_CHK   = 5'd3;
  localparam logic [4:0] ST_FRD   = 5'd4;
  localparam logic [4:0] ST_FWR   = 5'd5;
  localparam logic [4:0] ST_ADD   = 5'd6;
  localparam logic [4:0] ST_CMP   = 5'd7;
  localparam logic [4:0] ST_MATCH = 5'd8;
  localparam logic [4:0] ST_TRK1  = 5'd9;
  localparam logic [4:0] ST_TRK2  = 5'd10;
  localparam logic [4:0] ST_TRK3  = 5'd11;
  localparam logic [4:0] ST_TRK4  = 5'd12;
  localparam logic [4:0] ST_HRD   = 5'd13;
  localparam logic [4:0] ST_HSUB  = 5'd14;
  localparam logic [4:0] ST_HADD  = 5'd15;
  localparam logic [4:0] ST_DIVST = 5'd16;
  localparam logic [4:0] ST_DIVW  = 5'd17;
  localparam logic [4:0] ST_DONE  = 5'd18;

  function automatic logic [PTR_W-1:0] fifo_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [HP_W-1:0] hist_inc(input logic [HP_W-1:0] p);
    return (p == HP_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // control
  logic [4:0]        state_q, state_d;
  logic [SCNT_W-1:0] s_q, s_d;
  logic [SCNT_W-1:0] found_q, found_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [SW-1:0]     fs_q, fs_d;
  logic [SW-1:0]     dt_q, dt_d;
  logic [FCNT_W-1:0] fill_q [NUM_STREAMS];
  logic [FCNT_W-1:0] fill_d [NUM_STREAMS];
  logic [PTR_W-1:0]  rdptr_q [NUM_STREAMS];
  logic [PTR_W-1:0]  rdptr_d [NUM_STREAMS];
  logic [PTR_W-1:0]  wrptr_q [NUM_STREAMS];
  logic [PTR_W-1:0]  wrptr_d [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] hv_q, hv_d;
  logic signed [tcb_pkg::WIN_W-1:0] win_low_q  [tcb_pkg::MAX_STREAMS];
  logic signed [tcb_pkg::WIN_W-1:0] win_low_d  [tcb_pkg::MAX_STREAMS];
  logic signed [tcb_pkg::WIN_W-1:0] win_high_q [tcb_pkg::MAX_STREAMS];
  logic signed [tcb_pkg::WIN_W-1:0] win_high_d [tcb_pkg::MAX_STREAMS];
  logic              track_q, track_d;
  logic signed [tcb_pkg::HIST_W-1:0] avg_q [NUM_STREAMS];
  logic signed [tcb_pkg::HIST_W-1:0] avg_d [NUM_STREAMS];
  logic signed [SUM_W-1:0] sum_q [NUM_STREAMS];
  logic signed [SUM_W-1:0] sum_d [NUM_STREAMS];
  logic [HCNT_W-1:0] hfill_q [NUM_STREAMS];
  logic [HCNT_W-1:0] hfill_d [NUM_STREAMS];
  logic [HP_W-1:0]   hhead_q [NUM_STREAMS];
  logic [HP_W-1:0]   hhead_d [NUM_STREAMS];
  logic [HP_W-1:0]   htail_q [NUM_STREAMS];
  logic [HP_W-1:0]   htail_d [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] recalc_q, recalc_d;
  logic              pend_v_q, pend_v_d;
  logic              out_v_q, out_v_d;

  // payload
  logic [TD_W-1:0]   in_q, in_d;
  logic [tcb_pkg::STAMP_W-1:0] head_stamp_q [NUM_STREAMS];
  logic [tcb_pkg::STAMP_W-1:0] head_stamp_d [NUM_STREAMS];
  logic [tcb_pkg::EVENT_W-1:0] head_event_q [NUM_STREAMS];
  logic [tcb_pkg::EVENT_W-1:0] head_event_d [NUM_STREAMS];
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [D_W-1:0]    d_q, d_d;
  logic signed [REL_W-1:0]  rel_q, rel_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic signed [MEAN_W-1:0] half_q, half_d;
  logic signed [DEV1_W-1:0] dev1_q, dev1_d;
  logic signed [DEV1_W-1:0] v_q, v_d;
  logic signed [DEV_W-1:0]  dev_q, dev_d;
  logic signed [tcb_pkg::HIST_W-1:0] vsat_q, vsat_d;
  logic [TD_W-1:0]   pend_q, pend_d;
  logic [TD_W-1:0]   out_q, out_d;
  logic              out_last_q, out_last_d;

  // memories
  logic [ENT_W-1:0]  fifo_mem [NUM_STREAMS][FIFO_DEPTH];
  logic [ENT_W-1:0]  fifo_rd_q;
  logic [tcb_pkg::HIST_W-1:0] hist_mem [NUM_STREAMS][HISTORY_DEPTH];
  logic [tcb_pkg::HIST_W-1:0] hist_rd_q;

  // combinational helpers
  logic [SW-1:0]     si;
  logic [WI_W-1:0]   wi;
  logic [NUM_STREAMS-1:0] pop_mask;
  logic              push_en;
  logic              fetch_wr;
  logic              hist_we;
  logic              div_start;
  logic              load_out;
  logic              load_last;
  logic              out_free;
  logic              any_empty;
  logic              any_recalc;
  logic [SW-1:0]     dsel;
  logic [ENT_W-1:0]  push_ent;
  logic signed [D_W-1:0]    lo_x, hi_x;
  logic signed [DIFF_W-1:0] tdiff;
  logic signed [tcb_pkg::WIN_W:0] wsum, wdif;
  logic signed [DEV_W-1:0]  half_x;
  logic              div_done;
  logic signed [tcb_pkg::HIST_W-1:0] div_quot;

  assign si       = s_q[SW-1:0];
  assign wi       = WI_W'(si);
  assign out_free = !out_v_q || m_axis_tready_i;
  assign push_ent = {in_q[tcb_pkg::IN_EV_BASE + 32'(si) * tcb_pkg::EVENT_W +: tcb_pkg::EVENT_W],
                     in_q[32'(si) * tcb_pkg::STAMP_W +: tcb_pkg::STAMP_W]};
  assign lo_x   = D_W'($signed({win_low_q[wi], tcb_pkg::FRAC_W'(0)}));
  assign hi_x   = D_W'($signed({win_high_q[wi], tcb_pkg::FRAC_W'(0)}));
  assign tdiff  = $signed({1'b0, head_stamp_q[si]}) - $signed({1'b0, head_stamp_q[0]});
  assign wsum   = (tcb_pkg::WIN_W + 1)'(win_low_q[wi]) + (tcb_pkg::WIN_W + 1)'(win_high_q[wi]);
  assign wdif   = (tcb_pkg::WIN_W + 1)'(win_high_q[wi]) - (tcb_pkg::WIN_W + 1)'(win_low_q[wi]);
  assign half_x = DEV_W'(half_q);

  always_comb begin
    any_empty  = 1'b0;
    any_recalc = 1'b0;
    dsel       = '0;
    for (int k = NUM_STREAMS - 1; k >= 0; k--) begin
      if (fill_q[k] == '0) any_empty = 1'b1;
      if (recalc_q[k]) begin
        any_recalc = 1'b1;
        dsel       = SW'(k);
      end
    end
  end

  tcb_div #(
    .DVD_W (SUM_W),
    .DVS_W (HCNT_W),
    .Q_W   (tcb_pkg::HIST_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[dsel]),
    .divisor_i  (hfill_q[dsel]),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    s_d        = s_q;
    found_d    = found_q;
    n_d        = n_q;
    fs_d       = fs_q;
    dt_d       = dt_q;
    fill_d     = fill_q;
    rdptr_d    = rdptr_q;
    wrptr_d    = wrptr_q;
    hv_d       = hv_q;
    win_low_d  = win_low_q;
    win_high_d = win_high_q;
    track_d    = track_q;
    avg_d      = avg_q;
    sum_d      = sum_q;
    hfill_d    = hfill_q;
    hhead_d    = hhead_q;
    htail_d    = htail_q;
    recalc_d   = recalc_q;
    pend_v_d   = pend_v_q;
    out_v_d    = out_v_q;
    in_d       = in_q;
    head_stamp_d = head_stamp_q;
    head_event_d = head_event_q;
    diff_d     = diff_q;
    d_d        = d_q;
    rel_d      = rel_q;
    mean_d     = mean_q;
    half_d     = half_q;
    dev1_d     = dev1_q;
    v_d        = v_q;
    dev_d      = dev_q;
    vsat_d     = vsat_q;
    pend_d     = pend_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    pop_mask   = '0;
    push_en    = 1'b0;
    fetch_wr   = 1'b0;
    hist_we    = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        tcb_pkg::REG_WIN_LOW_1:  win_low_d[1]  = $signed(cfg_data_i);
        tcb_pkg::REG_WIN_HIGH_1: win_high_d[1] = $signed(cfg_data_i);
        tcb_pkg::REG_WIN_LOW_2:  win_low_d[2]  = $signed(cfg_data_i);
        tcb_pkg::REG_WIN_HIGH_2: win_high_d[2] = $signed(cfg_data_i);
        tcb_pkg::REG_WIN_LOW_3:  win_low_d[3]  = $signed(cfg_data_i);
        tcb_pkg::REG_WIN_HIGH_3: win_high_d[3] = $signed(cfg_data_i);
        tcb_pkg::REG_TRACK:      track_d       = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          in_d    = s_axis_tdata_i;
          s_d     = '0;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push_en = 1'b1;
        if (fill_q[si] == FCNT_W'(FIFO_DEPTH)) pop_mask[si] = 1'b1;
        if (s_q == SCNT_W'(NUM_STREAMS - 1)) begin
          n_d     = '0;
          state_d = ST_START;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      ST_START: begin
        if (n_q == N_W'(tcb_pkg::MAX_RESULTS) || fill_q[0] == '0) begin
          state_d = ST_DONE;
        end else begin
          found_d = SCNT_W'(1);
          s_d     = SCNT_W'(1);
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (s_q == SCNT_W'(NUM_STREAMS)) begin
          if (found_q == SCNT_W'(NUM_STREAMS)) state_d = ST_MATCH;
          else if (any_empty)                  state_d = ST_DONE;
          else                                 state_d = ST_START;
        end else if (fill_q[si] == '0) begin
          s_d = s_q + 1'b1;
        end else if (!hv_q[si]) begin
          fs_d    = si;
          state_d = ST_FRD;
        end else if (!hv_q[0]) begin
          fs_d    = '0;
          state_d = ST_FRD;
        end else begin
          diff_d  = tdiff;
          state_d = ST_ADD;
        end
      end
      ST_FRD: state_d = ST_FWR;
      ST_FWR: begin
        fetch_wr = 1'b1;
        state_d  = ST_CHK;
      end
      ST_ADD: begin
        d_d     = D_W'($signed({diff_q, tcb_pkg::FRAC_W'(0)})) + D_W'(avg_q[si]);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (d_q < lo_x) begin
          pop_mask[si] = 1'b1;
          state_d = (fill_q[si] == FCNT_W'(1)) ? ST_DONE : ST_CHK;
        end else if (d_q > hi_x) begin
          pop_mask[0] = 1'b1;
          found_d = SCNT_W'(1);
          state_d = (fill_q[0] == FCNT_W'(1)) ? ST_DONE : ST_CHK;
        end else begin
          found_d = found_q + 1'b1;
          s_d     = s_q + 1'b1;
          state_d = ST_CHK;
        end
      end
      ST_MATCH: begin
        if (!(pend_v_q && !out_free)) begin
          if (pend_v_q) load_out = 1'b1;
          pend_d = '0;
          for (int k = 0; k < NUM_STREAMS; k++) begin
            pend_d[k * tcb_pkg::EVENT_W +: tcb_pkg::EVENT_W] = head_event_q[k];
            pend_d[tcb_pkg::OUT_ST_BASE + k * tcb_pkg::STAMP_W +: tcb_pkg::STAMP_W] =
              head_stamp_q[k];
          end
          pend_v_d = 1'b1;
          pop_mask = '1;
          n_d      = n_q + 1'b1;
          if (track_q) begin
            s_d     = SCNT_W'(1);
            state_d = ST_TRK1;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_TRK1: begin
        if (s_q == SCNT_W'(NUM_STREAMS)) begin
          state_d = ST_DIVST;
        end else begin
          rel_d   = $signed({tdiff, tcb_pkg::FRAC_W'(0)});
          mean_d  = $signed({wsum, (tcb_pkg::FRAC_W - 1)'(0)});
          half_d  = $signed({wdif, (tcb_pkg::FRAC_W - 1)'(0)});
          state_d = ST_TRK2;
        end
      end
      ST_TRK2: begin
        dev1_d  = DEV1_W'(rel_q) - DEV1_W'(mean_q);
        v_d     = DEV1_W'(mean_q) - DEV1_W'(rel_q);
        state_d = ST_TRK3;
      end
      ST_TRK3: begin
        dev_d = DEV_W'(dev1_q) + DEV_W'(avg_q[si]);
        if (v_q > DEV1_W'(tcb_pkg::HIST_MAX))      vsat_d = tcb_pkg::HIST_MAX;
        else if (v_q < DEV1_W'(tcb_pkg::HIST_MIN)) vsat_d = tcb_pkg::HIST_MIN;
        else                                       vsat_d = $signed(v_q[tcb_pkg::HIST_W-1:0]);
        state_d = ST_TRK4;
      end
      ST_TRK4: begin
        if (dev_q < half_x && dev_q > -half_x) begin
          state_d = ST_HRD;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = ST_TRK1;
        end
      end
      ST_HRD: state_d = ST_HSUB;
      ST_HSUB: begin
        if (hfill_q[si] == HCNT_W'(HISTORY_DEPTH))
          sum_d[si] = sum_q[si] - SUM_W'($signed(hist_rd_q));
        state_d = ST_HADD;
      end
      ST_HADD: begin
        hist_we   = 1'b1;
        sum_d[si] = sum_q[si] + SUM_W'(vsat_q);
        htail_d[si] = hist_inc(htail_q[si]);
        if (hfill_q[si] == HCNT_W'(HISTORY_DEPTH)) hhead_d[si] = hist_inc(hhead_q[si]);
        else hfill_d[si] = hfill_q[si] + 1'b1;
        recalc_d[si] = 1'b1;
        s_d     = s_q + 1'b1;
        state_d = ST_TRK1;
      end
      ST_DIVST: begin
        if (any_recalc) begin
          div_start = 1'b1;
          dt_d      = dsel;
          state_d   = ST_DIVW;
        end else begin
          state_d = ST_START;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          avg_d[dt_q]    = div_quot;
          recalc_d[dt_q] = 1'b0;
          state_d        = ST_DIVST;
        end
      end
      ST_DONE: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          load_out  = 1'b1;
          load_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    for (int k = 0; k < NUM_STREAMS; k++) begin
      if (pop_mask[k]) begin
        rdptr_d[k] = fifo_inc(rdptr_q[k]);
        hv_d[k]    = 1'b0;
      end
      if (push_en && si == SW'(k)) wrptr_d[k] = fifo_inc(wrptr_q[k]);
      if (push_en && si == SW'(k) && !pop_mask[k]) fill_d[k] = fill_q[k] + 1'b1;
      else if (pop_mask[k] && !(push_en && si == SW'(k))) fill_d[k] = fill_q[k] - 1'b1;
      if (fetch_wr && fs_q == SW'(k)) begin
        head_stamp_d[k] = fifo_rd_q[tcb_pkg::STAMP_W-1:0];
        head_event_d[k] = fifo_rd_q[ENT_W-1:tcb_pkg::STAMP_W];
        hv_d[k]         = 1'b1;
      end
    end

    if (load_out) begin
      out_d      = pend_q;
      out_last_d = load_last;
      out_v_d    = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      s_q      <= '0;
      found_q  <= '0;
      n_q      <= '0;
      fs_q     <= '0;
      dt_q     <= '0;
      hv_q     <= '0;
      track_q  <= 1'b0;
      recalc_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int k = 0; k < NUM_STREAMS; k++) begin
        fill_q[k]  <= '0;
        rdptr_q[k] <= '0;
        wrptr_q[k] <= '0;
        avg_q[k]   <= '0;
        sum_q[k]   <= '0;
        hfill_q[k] <= '0;
        hhead_q[k] <= '0;
        htail_q[k] <= '0;
      end
      for (int k = 0; k < tcb_pkg::MAX_STREAMS; k++) begin
        win_low_q[k]  <= tcb_pkg::WIN_LOW_RST;
        win_high_q[k] <= tcb_pkg::WIN_HIGH_RST;
      end
    end else begin
      state_q    <= state_d;
      s_q        <= s_d;
      found_q    <= found_d;
      n_q        <= n_d;
      fs_q       <= fs_d;
      dt_q       <= dt_d;
      hv_q       <= hv_d;
      track_q    <= track_d;
      recalc_q   <= recalc_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      fill_q     <= fill_d;
      rdptr_q    <= rdptr_d;
      wrptr_q    <= wrptr_d;
      avg_q      <= avg_d;
      sum_q      <= sum_d;
      hfill_q    <= hfill_d;
      hhead_q    <= hhead_d;
      htail_q    <= htail_d;
      win_low_q  <= win_low_d;
      win_high_q <= win_high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q         <= in_d;
    head_stamp_q <= head_stamp_d;
    head_event_q <= head_event_d;
    diff_q       <= diff_d;
    d_q          <= d_d;
    rel_q        <= rel_d;
    mean_q       <= mean_d;
    half_q       <= half_d;
    dev1_q       <= dev1_d;
    v_q          <= v_d;
    dev_q        <= dev_d;
    vsat_q       <= vsat_d;
    pend_q       <= pend_d;
    out_q        <= out_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (push_en) fifo_mem[si][wrptr_q[si]] <= push_ent;
    fifo_rd_q <= fifo_mem[fs_q][rdptr_q[fs_q]];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[si][htail_q[si]] <= vsat_q;
    hist_rd_q <= hist_mem[si][hhead_q[si]];
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;

endmodule

`default_nettype wire

@@ tb/sv/timestamp_coincidence_event_builder_top_tb.sv @@
// ----------------------------------------------------------------------------
// timestamp_coincidence_event_builder_top_tb
// Self-checking bench for the four-stream coincidence event builder.
// ----------------------------------------------------------------------------
// Beats of stream timestamps go in on s_axis with random gaps; a local model
// of the per-stream FIFOs, windows and offset histories predicts every match
// beat, and each m_axis beat is checked field by field against the oldest
// prediction. Windows and offset tracking are rewritten between phases while
// the block is idle. One phase holds m_axis off long enough to stall input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_coincidence_event_builder_top_tb;

  localparam int NS         = 4;
  localparam int FIFO_DEPTH = 16;
  localparam int HIST_DEPTH = 11;
  localparam int SETTLE     = 400;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [tcb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [tcb_pkg::STAMP_W-1:0] stamp [NS];
    logic [tcb_pkg::EVENT_W-1:0] evt   [NS];
  } beat_t;

  typedef struct {
    logic [tcb_pkg::STAMP_W-1:0] stamp [NS];
    logic [tcb_pkg::EVENT_W-1:0] evt   [NS];
    logic                        last;
  } match_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic                           s_ready;
  logic [tcb_pkg::TDATA_W-1:0]    s_data = '0;
  logic                           m_valid;
  logic                           m_ready = 1'b0;
  logic [tcb_pkg::TDATA_W-1:0]    m_data;
  logic                           m_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  timestamp_coincidence_event_builder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [tcb_pkg::STAMP_W-1:0] stamp_q [NS][$];
  logic [tcb_pkg::EVENT_W-1:0] event_q [NS][$];
  longint             corr_hist [NS][$];
  longint             win_lo [NS];
  longint             win_hi [NS];
  bit                 track_on;
  match_t             expected_matches [$];

  int     errors = 0;
  int     beats_sent = 0;
  int     matches_seen = 0;
  int     cfg_writes = 0;
  bit     calm_tx = 0;
  bit     calm_rx = 0;
  int     hold_req = 0;
  int     stall_left = 0;
  longint now_tick;
  logic [tcb_pkg::EVENT_W-1:0] evt_ctr [NS];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic longint avg_correction(int s);
    longint sum;
    sum = 0;
    if (s < 1 || corr_hist[s].size() == 0) return 0;
    foreach (corr_hist[s][k]) sum += corr_hist[s][k];
    return sum / corr_hist[s].size();
  endfunction

  function automatic void drop_head(int s);
    if (stamp_q[s].size() > 0) begin
      stamp_q[s].delete(0);
      event_q[s].delete(0);
    end
  endfunction

  function automatic void apply_reg(logic [tcb_pkg::CFG_IDX_W-1:0] idx,
                                    logic [tcb_pkg::CFG_DATA_W-1:0] val);
    int s;
    s = idx / 2 + 1;
    if (idx <= tcb_pkg::REG_WIN_HIGH_3) begin
      if (idx[0]) win_hi[s] = longint'(signed'(val));
      else win_lo[s] = longint'(signed'(val));
    end else if (idx == tcb_pkg::REG_TRACK) begin
      track_on = val[0];
    end
  endfunction

  function automatic void build_matches(beat_t b);
    match_t m;
    match_t got [$];
    longint origin, d, ref_ts, ts, off, rel, mid, half, dev, v;
    int     found, n;
    bit     stop, hole;
    n = 0;
    stop = 0;
    for (int s = 0; s < NS; s++) begin
      if (stamp_q[s].size() >= FIFO_DEPTH) drop_head(s);
      stamp_q[s].insert(stamp_q[s].size(), b.stamp[s]);
      event_q[s].insert(event_q[s].size(), b.evt[s]);
    end
    while (n < tcb_pkg::MAX_RESULTS && stamp_q[0].size() > 0) begin
      origin = {16'd0, stamp_q[0][0]};
      found = 1;
      for (int s = 1; s < NS && !stop; s++) begin
        while (stamp_q[s].size() > 0) begin
          d = ({16'd0, stamp_q[s][0]} - origin) * 256 + avg_correction(s);
          if (d < win_lo[s] * 256) begin
            drop_head(s);
            if (stamp_q[s].size() == 0) begin
              stop = 1;
              break;
            end
          end else if (d > win_hi[s] * 256) begin
            drop_head(0);
            if (stamp_q[0].size() == 0) begin
              stop = 1;
              break;
            end
            origin = {16'd0, stamp_q[0][0]};
            found = 1;
          end else begin
            found++;
            break;
          end
        end
      end
      if (stop) break;
      if (found != NS) begin
        hole = 0;
        for (int s = 0; s < NS; s++) if (stamp_q[s].size() == 0) hole = 1;
        if (hole) break;
        continue;
      end
      ref_ts = {16'd0, stamp_q[0][0]};
      m.last = 1'b0;
      for (int s = 0; s < NS; s++) begin
        ts = {16'd0, stamp_q[s][0]};
        off = avg_correction(s);
        m.stamp[s] = stamp_q[s][0];
        m.evt[s] = event_q[s][0];
        drop_head(s);
        if (track_on && s > 0) begin
          rel = (ts - ref_ts) * 256;
          mid = (win_lo[s] + win_hi[s]) * 128;
          half = (win_hi[s] - win_lo[s]) * 128;
          dev = rel + off - mid;
          if (dev < 0) dev = -dev;
          if (dev < half) begin
            v = mid - rel;
            if (v > longint'(tcb_pkg::HIST_MAX)) v = longint'(tcb_pkg::HIST_MAX);
            if (v < longint'(tcb_pkg::HIST_MIN)) v = longint'(tcb_pkg::HIST_MIN);
            if (corr_hist[s].size() >= HIST_DEPTH) corr_hist[s].delete(0);
            corr_hist[s].insert(corr_hist[s].size(), v);
          end
        end
      end
      got.insert(got.size(), m);
      n++;
    end
    if (n > 0) got[n-1].last = 1'b1;
    foreach (got[k]) expected_matches.insert(expected_matches.size(), got[k]);
  endfunction

  // stimulus helpers
  function automatic beat_t make_beat(bit clean);
    beat_t  b;
    longint off, span;
    int     r;
    now_tick += $urandom_range(5000, 100000);
    if ($urandom_range(0, 49) == 0) now_tick = 64'hFFFF_FFFF_FFFF - $urandom_range(0, 1 << 24);
    if (now_tick > 64'hFFFF_FFFF_FFFF) now_tick = {$urandom_range(0, 1 << 14), 20'd0};
    b.stamp[0] = now_tick[tcb_pkg::STAMP_W-1:0];
    for (int s = 0; s < NS; s++) begin
      evt_ctr[s] += 1;
      b.evt[s] = ($urandom_range(0, 9) == 0) ? $urandom() : evt_ctr[s];
    end
    for (int s = 1; s < NS; s++) begin
      span = win_hi[s] - win_lo[s];
      if (span >= 0 && span < 1000000) off = win_lo[s] + $urandom_range(0, span);
      else off = longint'($urandom_range(0, 2000)) - 1000;
      r = clean ? 0 : $urandom_range(0, 99);
      if (r < 70) b.stamp[s] = now_tick + off;
      else if (r < 80) b.stamp[s] = now_tick - $urandom_range(3000, 200000);
      else if (r < 90) b.stamp[s] = now_tick + $urandom_range(3000, 200000);
      else b.stamp[s] = {$urandom(), $urandom()};
    end
    if (!clean && $urandom_range(0, 19) == 0) b.stamp[0] = {$urandom(), $urandom()};
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    int gap;
    gap = (calm_tx || $urandom_range(0, 99) < 40) ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int s = 0; s < NS; s++) begin
      s_data[s*tcb_pkg::STAMP_W +: tcb_pkg::STAMP_W] = b.stamp[s];
      s_data[tcb_pkg::IN_EV_BASE + s*tcb_pkg::EVENT_W +: tcb_pkg::EVENT_W] = b.evt[s];
    end
    s_valid = 1'b1;
    do @(posedge clk_i); while (!s_ready);
    build_matches(b);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_offsets(input longint t0, input longint o1, input longint o2,
                              input longint o3);
    beat_t b;
    b = make_beat(1);
    b.stamp[0] = t0;
    b.stamp[1] = t0 + o1;
    b.stamp[2] = t0 + o2;
    b.stamp[3] = t0 + o3;
    send_beat(b);
  endtask

  task automatic wait_idle();
    s_valid = 1'b0;
    do @(posedge clk_i); while (expected_matches.size() != 0 || !s_ready);
    @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [tcb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcb_pkg::CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_windows(input int l1, input int h1, input int l2, input int h2,
                             input int l3, input int h3);
    cfg_write(tcb_pkg::REG_WIN_LOW_1, l1);
    cfg_write(tcb_pkg::REG_WIN_HIGH_1, h1);
    cfg_write(tcb_pkg::REG_WIN_LOW_2, l2);
    cfg_write(tcb_pkg::REG_WIN_HIGH_2, h2);
    cfg_write(tcb_pkg::REG_WIN_LOW_3, l3);
    cfg_write(tcb_pkg::REG_WIN_HIGH_3, h3);
  endtask

  task automatic send_random(input int count, input int clean_pct);
    repeat (count) send_beat(make_beat($urandom_range(0, 99) < clean_pct));
  endtask

  // tests
  task automatic test_default_windows();
    send_offsets(0, 0, 0, 0);
    send_beat('{stamp: '{default: '1}, evt: '{default: '1}});
    send_beat('{stamp: '{default: '0}, evt: '{default: '0}});
    send_offsets(48'h8000_0000_0000, -1000, 1000, 0);
    send_offsets(48'h8000_0010_0000, -1001, 0, 0);
    send_offsets(48'h8000_0020_0000, 0, 0, 0);
    send_offsets(48'h8000_0030_0000, 0, 1001, 0);
    send_offsets(48'h8000_0040_0000, 3, -7, 999);
    send_offsets(48'h8000_0050_0000, -500, 0, -999);
    for (int k = 0; k < 18; k++) send_offsets(48'h9000_0000_0000 + k * 5000, 0, 0, 5000000);
    send_offsets(48'hA000_0000_0000, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_window_edges();
    set_windows(-32'sd2147483648, 32'sd2147483647, 32'sd0, 32'sd0, 32'sd100, -32'sd100);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_offsets(48'h4000_0000_0000, 32'sd2147483647, 0, 0);
    send_offsets(48'h4000_1000_0000, -32'sd2147483648, 0, 0);
    send_offsets(48'h4000_2000_0000, 0, 1, 0);
    send_random(12, 50);
    wait_idle();
    set_windows(-200, 600, 100, 3000, -5000, -10);
    send_random(20, 75);
    wait_idle();
  endtask

  task automatic test_offset_tracking();
    cfg_write(tcb_pkg::REG_TRACK, 32'd1);
    set_windows(-1000, 1000, -300, 700, 0, 2000);
    send_random(30, 85);
    wait_idle();
    set_windows(-32'sd2147483648, 32'sd2147483647, -50, 50, -32'sd2147483648, -32'sd2147483000);
    send_offsets(48'h1000_0000_0000, -32'sd2147483600, 10, -32'sd2147483200);
    send_random(12, 60);
    wait_idle();
    cfg_write(tcb_pkg::REG_TRACK, 32'd0);
  endtask

  task automatic test_output_stall();
    set_windows(-1000, 1000, -1000, 1000, -1000, 1000);
    calm_tx = 1;
    hold_req = 3000;
    send_random(30, 100);
    calm_tx = 0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    calm_rx = 1;
    calm_tx = 1;
    send_random(20, 80);
    calm_rx = 0;
    calm_tx = 0;
    wait_idle();
    cfg_write(tcb_pkg::REG_TRACK, 32'd1);
    set_windows(-400, 400, -2000, 100, 50, 900);
    send_random(30, 80);
    wait_idle();
    cfg_write(tcb_pkg::REG_TRACK, 32'd0);
    set_windows(-1000, 1000, -1000, 1000, -1000, 1000);
    send_random(30, 70);
    wait_idle();
  endtask

  // m_axis ready with random stalls and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        m_ready = 1'b0;
        repeat (hold_req) @(negedge clk_i);
        hold_req = 0;
      end
      if (stall_left > 0) begin
        m_ready = 1'b0;
        stall_left--;
      end else begin
        m_ready = 1'b1;
        if (!calm_rx && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    match_t      e;
    logic [47:0] got_st;
    logic [31:0] got_ev;
    if (m_valid && m_ready) begin
      matches_seen++;
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match beat %h", $time, m_data);
        errors++;
      end else begin
        e = expected_matches[0];
        expected_matches.delete(0);
        for (int s = 0; s < NS; s++) begin
          got_ev = m_data[s*tcb_pkg::EVENT_W +: tcb_pkg::EVENT_W];
          got_st = m_data[tcb_pkg::OUT_ST_BASE + s*tcb_pkg::STAMP_W +: tcb_pkg::STAMP_W];
          if (got_ev !== e.evt[s]) begin
            $display("%0t: event %0d expected %h got %h", $time, s, e.evt[s], got_ev);
            errors++;
          end
          if (got_st !== e.stamp[s]) begin
            $display("%0t: stamp %0d expected %h got %h", $time, s, e.stamp[s], got_st);
            errors++;
          end
        end
        if (m_last !== e.last) begin
          $display("%0t: tlast expected %b got %b", $time, e.last, m_last);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NS; s++) begin
      win_lo[s] = -1000;
      win_hi[s] = 1000;
      evt_ctr[s] = $urandom();
    end
    track_on = 0;
    now_tick = {$urandom_range(1, 1 << 14), 20'd0};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_windows();
    test_window_edges();
    test_offset_tracking();
    test_output_stall();
    test_random_traffic();

    wait_idle();
    $display("Sent %0d input beats, checked %0d match beats, %0d register writes.",
             beats_sent, matches_seen, cfg_writes);
    $display("Covered default, extreme and inverted windows, offset tracking and a long stall.");
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
